// ===== rtl/euler_angles_to_basis_vectors_assert.svh =====
// Assertion macros for the checker module of this block.
// Every macro samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_ASSERT_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_ASSERT_SVH

// The consequent must hold in the cycle in which the antecedent holds.
`define EABV_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eabv_checker: implication violated");

// The condition must never be true out of reset.
`define EABV_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("eabv_checker: forbidden condition seen");

`endif

// ===== rtl/eabv_pkg.sv =====
package eabv_pkg;

  // Angle inputs: a full turn is 2^ANGLE_BITS units.
  localparam int ANGLE_BITS = 16;
  // Results are Q1.FRAC_BITS, two's complement.
  localparam int FRAC_BITS = 14;
  localparam int OUT_BITS = FRAC_BITS + 2;
  localparam int UNIT = 1 << FRAC_BITS;

  // CORDIC datapath: x and y are Q.40 with headroom, z is a 32-bit phase.
  localparam int CORDIC_STEPS = 30;
  localparam int INNER_BITS = 40;
  localparam int XY_BITS = INNER_BITS + 3;
  localparam int Z_BITS = 32;
  localparam int RES_BITS = 30;

  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY = CORDIC_STEPS + 4;

  localparam logic signed [XY_BITS-1:0] INNER_GAIN = XY_BITS'(64'sd667681663043);

  localparam logic [Z_BITS-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [OUT_BITS-1:0] unit_t;

  // Sine and cosine of one angle, as handed from a CORDIC pipe to the mixer.
  typedef struct packed {
    logic  valid;
    unit_t sn;
    unit_t cs;
  } sincos_t;

endpackage

// ===== rtl/eabv_cordic.sv =====
module eabv_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  eabv_pkg::angle_t  angle_i,
  output eabv_pkg::sincos_t sc_o
);

  localparam int Steps = eabv_pkg::CORDIC_STEPS;
  localparam int XW = eabv_pkg::XY_BITS;
  localparam int ZW = eabv_pkg::Z_BITS;
  localparam int AB = eabv_pkg::ANGLE_BITS;
  localparam int OW = eabv_pkg::OUT_BITS;
  localparam int ShiftOut = eabv_pkg::INNER_BITS - eabv_pkg::FRAC_BITS;
  localparam logic signed [XW-1:0] RoundHalf = XW'(1) << (ShiftOut - 1);
  localparam logic signed [XW-1:0] UnitX = XW'(eabv_pkg::UNIT);
  localparam eabv_pkg::unit_t UnitOut = OW'(eabv_pkg::UNIT);

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  logic signed [XW-1:0] x_s [Steps];
  logic signed [XW-1:0] y_s [Steps];
  logic signed [ZW-1:0] z_s [Steps];
  logic signed [XW-1:0] x_d [Steps];
  logic signed [XW-1:0] y_d [Steps];
  logic signed [ZW-1:0] z_d [Steps];
  logic signed [XW-1:0] x_q [Steps];
  logic signed [XW-1:0] y_q [Steps];
  logic signed [ZW-1:0] z_q [Steps];
  quad_e                quad_q [Steps];
  logic                 zero_q [Steps];
  logic [Steps-1:0]     valid_q;

  logic [eabv_pkg::RES_BITS-1:0] res;
  eabv_pkg::unit_t               sn_raw, cs_raw;
  eabv_pkg::sincos_t             sc_d, sc_q;

  function automatic eabv_pkg::unit_t from_inner(logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v + RoundHalf) >>> ShiftOut;
    if (t > UnitX) begin
      return UnitOut;
    end else if (t < -UnitX) begin
      return -UnitOut;
    end
    return t[OW-1:0];
  endfunction

  // The residual angle within the quadrant, as a 30-bit phase.
  assign res = eabv_pkg::RES_BITS'(angle_i[AB-3:0]) << (eabv_pkg::RES_BITS - (AB - 2));

  always_comb begin
    x_s[0] = eabv_pkg::INNER_GAIN;
    y_s[0] = '0;
    z_s[0] = $signed(ZW'(res));
    for (int i = 1; i < Steps; i++) begin
      x_s[i] = x_q[i-1];
      y_s[i] = y_q[i-1];
      z_s[i] = z_q[i-1];
    end
    for (int i = 0; i < Steps; i++) begin
      if (!z_s[i][ZW-1]) begin
        x_d[i] = x_s[i] - (y_s[i] >>> i);
        y_d[i] = y_s[i] + (x_s[i] >>> i);
        z_d[i] = z_s[i] - $signed(eabv_pkg::STEP_ANGLE[i]);
      end else begin
        x_d[i] = x_s[i] + (y_s[i] >>> i);
        y_d[i] = y_s[i] - (x_s[i] >>> i);
        z_d[i] = z_s[i] + $signed(eabv_pkg::STEP_ANGLE[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    quad_q[0] <= quad_e'(angle_i[AB-1 -: 2]);
    zero_q[0] <= (angle_i[AB-3:0] == '0);
    for (int i = 1; i < Steps; i++) begin
      quad_q[i] <= quad_q[i-1];
      zero_q[i] <= zero_q[i-1];
    end
  end

  // A residual of zero gives an exact sine of zero and cosine of one.
  always_comb begin
    if (zero_q[Steps-1]) begin
      sn_raw = '0;
      cs_raw = UnitOut;
    end else begin
      sn_raw = from_inner(y_q[Steps-1]);
      cs_raw = from_inner(x_q[Steps-1]);
    end
    sc_d.valid = valid_q[Steps-1];
    unique case (quad_q[Steps-1])
      QUAD_0: begin
        sc_d.sn = sn_raw;
        sc_d.cs = cs_raw;
      end
      QUAD_1: begin
        sc_d.sn = cs_raw;
        sc_d.cs = -sn_raw;
      end
      QUAD_2: begin
        sc_d.sn = -sn_raw;
        sc_d.cs = -cs_raw;
      end
      default: begin
        sc_d.sn = -cs_raw;
        sc_d.cs = sn_raw;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      sc_q    <= '0;
    end else begin
      valid_q <= {valid_q[Steps-2:0], valid_i};
      sc_q    <= sc_d;
    end
  end

  assign sc_o = sc_q;

endmodule

// ===== rtl/euler_angles_to_basis_vectors.sv =====
// Euler angles to basis vectors.
//
// A request carries pitch, yaw and roll as signed binary angles (a full turn is
// 65536 units) and is taken at a rising clock edge at which start_i is high and
// busy_o is low. The result is the forward, right and up unit vectors of that
// orientation as nine Q1.14 components, each clamped to plus or minus 16384.
// The result stands on the output ports for one cycle, marked by done_o, and the
// receiver takes it at the edge that ends that cycle; it cannot hold results off.
//
// The block is a fixed pipeline: a new request may enter in every cycle, and busy_o
// never rises. A request passes through 30 CORDIC stages (one micro-rotation per
// stage, one pipe per angle), one stage that rounds and folds in the quadrant, two
// stages of rounded products and one stage that adds, clamps and registers the
// outputs. The depth of the CORDIC sets the latency.
//
// Reset clears every valid bit at once, so no stale result is strobed after reset;
// the data registers need no reset. There is no configuration and no state kept
// from one request to the next.
module euler_angles_to_basis_vectors (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  eabv_pkg::angle_t pitch_i,
  input  eabv_pkg::angle_t yaw_i,
  input  eabv_pkg::angle_t roll_i,
  output logic             done_o,
  output eabv_pkg::unit_t  forward_x_o,
  output eabv_pkg::unit_t  forward_y_o,
  output eabv_pkg::unit_t  forward_z_o,
  output eabv_pkg::unit_t  right_x_o,
  output eabv_pkg::unit_t  right_y_o,
  output eabv_pkg::unit_t  right_z_o,
  output eabv_pkg::unit_t  up_x_o,
  output eabv_pkg::unit_t  up_y_o,
  output eabv_pkg::unit_t  up_z_o
);

  localparam int OW = eabv_pkg::OUT_BITS;
  localparam int SW = OW + 1;
  localparam int FB = eabv_pkg::FRAC_BITS;
  localparam logic signed [2*OW-1:0] ProdHalf = (2 * OW)'(1) << (FB - 1);
  localparam logic signed [SW-1:0] UnitS = SW'(eabv_pkg::UNIT);
  localparam eabv_pkg::unit_t UnitOut = OW'(eabv_pkg::UNIT);

  // Products of two factors, plus the values the second product stage needs.
  typedef struct packed {
    eabv_pkg::unit_t cxsy;
    eabv_pkg::unit_t cxcy;
    eabv_pkg::unit_t cxsz;
    eabv_pkg::unit_t cxcz;
    eabv_pkg::unit_t cycz;
    eabv_pkg::unit_t sycz;
    eabv_pkg::unit_t cysz;
    eabv_pkg::unit_t sysz;
    eabv_pkg::unit_t sxsy;
    eabv_pkg::unit_t sxcy;
    eabv_pkg::unit_t nsx;
    eabv_pkg::unit_t sz;
    eabv_pkg::unit_t cz;
  } prod1_t;

  // All terms of the nine components, ready to be added.
  typedef struct packed {
    eabv_pkg::unit_t cxsy;
    eabv_pkg::unit_t cxcy;
    eabv_pkg::unit_t cxsz;
    eabv_pkg::unit_t cxcz;
    eabv_pkg::unit_t cycz;
    eabv_pkg::unit_t sycz;
    eabv_pkg::unit_t cysz;
    eabv_pkg::unit_t sysz;
    eabv_pkg::unit_t nsx;
    eabv_pkg::unit_t sxsysz;
    eabv_pkg::unit_t sxcysz;
    eabv_pkg::unit_t sxsycz;
    eabv_pkg::unit_t sxcycz;
  } prod2_t;

  logic              accept;
  eabv_pkg::sincos_t sc_pitch, sc_yaw, sc_roll;
  prod1_t            p1_d, p1_q;
  prod2_t            p2_d, p2_q;
  logic              v1_q, v2_q, done_q;
  eabv_pkg::unit_t   fx_d, fy_d, fz_d, rx_d, ry_d, rz_d, ux_d, uy_d, uz_d;
  eabv_pkg::unit_t   fx_q, fy_q, fz_q, rx_q, ry_q, rz_q, ux_q, uy_q, uz_q;

  // Product of two Q1.14 values, rounded to nearest with ties upward.
  function automatic eabv_pkg::unit_t mul2(eabv_pkg::unit_t a, eabv_pkg::unit_t b);
    logic signed [2*OW-1:0] p;
    p = a * b;
    p = (p + ProdHalf) >>> FB;
    return p[OW-1:0];
  endfunction

  function automatic eabv_pkg::unit_t clamp_sum(logic signed [SW-1:0] v);
    if (v > UnitS) begin
      return UnitOut;
    end else if (v < -UnitS) begin
      return -UnitOut;
    end
    return v[OW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] widen(eabv_pkg::unit_t v);
    return SW'(v);
  endfunction

  // The pipeline never stalls, so every request is taken.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  eabv_cordic u_cordic_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .angle_i(pitch_i),
    .sc_o   (sc_pitch)
  );

  eabv_cordic u_cordic_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .angle_i(yaw_i),
    .sc_o   (sc_yaw)
  );

  eabv_cordic u_cordic_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .angle_i(roll_i),
    .sc_o   (sc_roll)
  );

  // First product stage: every two-factor product.
  always_comb begin
    p1_d.cxsy = mul2(sc_pitch.cs, sc_yaw.sn);
    p1_d.cxcy = mul2(sc_pitch.cs, sc_yaw.cs);
    p1_d.cxsz = mul2(sc_pitch.cs, sc_roll.sn);
    p1_d.cxcz = mul2(sc_pitch.cs, sc_roll.cs);
    p1_d.cycz = mul2(sc_yaw.cs, sc_roll.cs);
    p1_d.sycz = mul2(sc_yaw.sn, sc_roll.cs);
    p1_d.cysz = mul2(sc_yaw.cs, sc_roll.sn);
    p1_d.sysz = mul2(sc_yaw.sn, sc_roll.sn);
    p1_d.sxsy = mul2(sc_pitch.sn, sc_yaw.sn);
    p1_d.sxcy = mul2(sc_pitch.sn, sc_yaw.cs);
    p1_d.nsx  = -sc_pitch.sn;
    p1_d.sz   = sc_roll.sn;
    p1_d.cz   = sc_roll.cs;
  end

  // Second product stage: the three-factor products take the rounded pair
  // product times the roll term.
  always_comb begin
    p2_d.cxsy   = p1_q.cxsy;
    p2_d.cxcy   = p1_q.cxcy;
    p2_d.cxsz   = p1_q.cxsz;
    p2_d.cxcz   = p1_q.cxcz;
    p2_d.cycz   = p1_q.cycz;
    p2_d.sycz   = p1_q.sycz;
    p2_d.cysz   = p1_q.cysz;
    p2_d.sysz   = p1_q.sysz;
    p2_d.nsx    = p1_q.nsx;
    p2_d.sxsysz = mul2(p1_q.sxsy, p1_q.sz);
    p2_d.sxcysz = mul2(p1_q.sxcy, p1_q.sz);
    p2_d.sxsycz = mul2(p1_q.sxsy, p1_q.cz);
    p2_d.sxcycz = mul2(p1_q.sxcy, p1_q.cz);
  end

  // Last stage: exact sums, then every component is clamped to the unit range.
  always_comb begin
    fx_d = clamp_sum(widen(p2_q.cxsy));
    fy_d = clamp_sum(widen(p2_q.nsx));
    fz_d = clamp_sum(widen(p2_q.cxcy));
    rx_d = clamp_sum(widen(p2_q.sxsysz) + widen(p2_q.cycz));
    ry_d = clamp_sum(widen(p2_q.cxsz));
    rz_d = clamp_sum(widen(p2_q.sxcysz) - widen(p2_q.sycz));
    ux_d = clamp_sum(widen(p2_q.sxsycz) - widen(p2_q.cysz));
    uy_d = clamp_sum(widen(p2_q.cxcz));
    uz_d = clamp_sum(widen(p2_q.sysz) + widen(p2_q.sxcycz));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= sc_pitch.valid && sc_yaw.valid && sc_roll.valid;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    p2_q <= p2_d;
    fx_q <= fx_d;
    fy_q <= fy_d;
    fz_q <= fz_d;
    rx_q <= rx_d;
    ry_q <= ry_d;
    rz_q <= rz_d;
    ux_q <= ux_d;
    uy_q <= uy_d;
    uz_q <= uz_d;
  end

  assign done_o      = done_q;
  assign forward_x_o = fx_q;
  assign forward_y_o = fy_q;
  assign forward_z_o = fz_q;
  assign right_x_o   = rx_q;
  assign right_y_o   = ry_q;
  assign right_z_o   = rz_q;
  assign up_x_o      = ux_q;
  assign up_y_o      = uy_q;
  assign up_z_o      = uz_q;

endmodule

// ===== rtl/eabv_checker.sv =====
`include "euler_angles_to_basis_vectors_assert.svh"

module eabv_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input eabv_pkg::angle_t pitch_i,
  input eabv_pkg::angle_t yaw_i,
  input eabv_pkg::angle_t roll_i,
  input logic             done_o,
  input eabv_pkg::unit_t  forward_x_o,
  input eabv_pkg::unit_t  forward_y_o,
  input eabv_pkg::unit_t  forward_z_o,
  input eabv_pkg::unit_t  right_x_o,
  input eabv_pkg::unit_t  right_y_o,
  input eabv_pkg::unit_t  right_z_o,
  input eabv_pkg::unit_t  up_x_o,
  input eabv_pkg::unit_t  up_y_o,
  input eabv_pkg::unit_t  up_z_o
);

  localparam eabv_pkg::unit_t UnitOut = eabv_pkg::OUT_BITS'(eabv_pkg::UNIT);

  // The pipeline never pushes back.
  `EABV_ASSERT_NEVER(a_never_busy, busy_o)

  // Every result strobe belongs to a request taken a fixed latency earlier.
  `EABV_ASSERT_IMPLIES(a_done_has_request, done_o,
                       $past(start_i && !busy_o, eabv_pkg::LATENCY))

  // Level pitch gives a forward vector with no vertical part.
  `EABV_ASSERT_IMPLIES(a_level_forward_y,
                       done_o && $past(pitch_i == '0, eabv_pkg::LATENCY),
                       forward_y_o == '0)

  // Zero pitch and yaw point forward straight along Z.
  `EABV_ASSERT_IMPLIES(a_zero_forward_z,
                       done_o && $past(pitch_i == '0 && yaw_i == '0, eabv_pkg::LATENCY),
                       forward_z_o == UnitOut)

endmodule

bind euler_angles_to_basis_vectors eabv_checker u_eabv_checker (.*);
